FILE: design/mws_pkg.sv
// Shared constants, curve codes and the table builder for the waveshaper.
// Used by multimode_waveshaper; has no dependencies of its own.
package mws_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int TABLE_DEPTH  = 1024;

   localparam int FRAC_BITS = SAMPLE_WIDTH - 4;
   localparam int TAB_BITS  = $clog2(TABLE_DEPTH);
   // table entries lie in [-1, 1], two integer bits are enough
   localparam int TAB_W     = FRAC_BITS + 2;
   localparam int ROW_W     = 6 * TAB_W;
   localparam int MODE_W    = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_BYPASS = 3'd0,
      MODE_TANH   = 3'd1,
      MODE_ATAN   = 3'd2,
      MODE_CLIP   = 3'd3,
      MODE_RECT   = 3'd4,
      MODE_SINE   = 3'd5
   } mode_type;

   typedef enum int {
      CURVE_TANH = 0,
      CURVE_ATAN = 1,
      CURVE_SINE = 2
   } curve_type;

   typedef logic signed [TAB_W-1:0] tab_type [0:TABLE_DEPTH];

   // Q28 arithmetic used only while the tables are elaborated
   localparam int          QB        = 28;
   localparam logic [63:0] ONE_Q     = 64'd1 << QB;
   localparam logic [63:0] PI_Q      = 64'd843314857;
   localparam logic [63:0] HALF_PI_Q = 64'd421657428;
   localparam logic [63:0] LN2_Q     = 64'd186065279;

   // unsigned 64-bit quotient by shift and subtract, truncated toward zero
   function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
      logic [63:0] n;
      logic [63:0] res;
      logic [63:0] bit_v;
      n     = n_in;
      res   = 64'd0;
      bit_v = 64'd1 << 62;
      while (bit_v > n) bit_v = bit_v >> 2;
      while (bit_v != 64'd0) begin
         if (n >= res + bit_v) begin
            n   = n - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   function automatic longint tanh_q(input logic [63:0] y);
      logic [63:0] z;
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] em;
      z    = y << 1;
      n    = div64(z, LN2_Q);
      r    = z - n * LN2_Q;
      sum  = ONE_Q;
      term = ONE_Q;
      for (int k = 1; k <= 16; k++) begin
         term = div64((term * r) >> QB, 64'(k));
         sum  = sum + term;
      end
      em = div64(64'd1 << (2 * QB), sum);
      em = (n < 64'd63) ? (em >> n) : 64'd0;
      return longint'(div64((ONE_Q - em) << QB, ONE_Q + em));
   endfunction

   function automatic longint atan_q(input logic [63:0] y_in);
      logic [63:0] y;
      logic [63:0] s;
      logic [63:0] y2;
      logic [63:0] p;
      longint      sum;
      longint      t;
      y = y_in;
      for (int k = 0; k < 3; k++) begin
         s = isqrt64(ONE_Q * ONE_Q + y * y);
         y = div64(y << QB, ONE_Q + s);
      end
      y2  = (y * y) >> QB;
      p   = y;
      sum = longint'(y);
      for (int k = 1; k <= 8; k++) begin
         p   = (p * y2) >> QB;
         t   = longint'(div64(p, 64'(2 * k + 1)));
         sum = ((k & 1) == 1) ? sum - t : sum + t;
      end
      if (sum < 0) sum = 0;
      return longint'(div64((64'(sum) * 64'd8) << 29, PI_Q));
   endfunction

   function automatic longint sin_q(input logic [63:0] y_in);
      logic [63:0] y;
      logic [63:0] y2;
      logic [63:0] t;
      logic        neg;
      longint      sum;
      y   = y_in;
      neg = 1'b0;
      while (y >= PI_Q) begin
         y   = y - PI_Q;
         neg = ~neg;
      end
      if (y > HALF_PI_Q) y = PI_Q - y;
      y2  = (y * y) >> QB;
      t   = y;
      sum = longint'(y);
      for (int k = 1; k <= 8; k++) begin
         t   = div64((t * y2) >> QB, 64'((2 * k) * (2 * k + 1)));
         sum = ((k & 1) == 1) ? sum - longint'(t) : sum + longint'(t);
      end
      if (sum < 0) sum = 0;
      return neg ? -sum : sum;
   endfunction

   // round half up from Q28 to the sample fraction
   function automatic longint to_sample(input longint vq);
      return (vq + (longint'(1) <<< (QB - FRAC_BITS - 1))) >>> (QB - FRAC_BITS);
   endfunction

   // entry k holds f(8k/TABLE_DEPTH)
   function automatic tab_type build_tab(input curve_type which);
      tab_type     tab;
      logic [63:0] y;
      longint      v;
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         y = div64(64'(k) << 31, 64'(TABLE_DEPTH));
         case (which)
            CURVE_TANH: v = tanh_q(y);
            CURVE_ATAN: v = atan_q(y);
            CURVE_SINE: v = sin_q(y);
            default:    v = 0;
         endcase
         tab[k] = TAB_W'(to_sample(v));
      end
      return tab;
   endfunction

endpackage

FILE: design/mws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the curve tables of the waveshaper.
module mws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: design/multimode_waveshaper.sv
// Multimode waveshaper: bypass, tanh, atan*2/pi, hard clip, rectify, sine.
// Stages A, B, C and an output register; throughput one request per cycle while results
//   are taken, set by the three-stage pipe around the one-read-per-cycle table RAM.
// Reset (synchronous, active high): mode returns to bypass, pipe empties, then a fill sweep
//   writes the table RAM while req_tready stays low; CSR writes are taken throughout.
// Depends on mws_pkg and mws_ram.
module multimode_waveshaper
   import mws_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // input requests
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [SAMPLE_WIDTH-1:0] req_tdata,    // [15:0] sample_in
   // shaped results
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [SAMPLE_WIDTH-1:0] rsp_tdata,    // [15:0] sample_out
   // mode register write
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [MODE_W-1:0]       csr_wdata     // [2:0] mode
);

   localparam int SW     = SAMPLE_WIDTH;
   localparam int FW     = SW - 1;                // interpolation fraction bits
   localparam int POS_W  = SW + TAB_BITS;
   localparam int PROD_W = TAB_W + SW + 1;
   localparam int Y_W    = SW + 2;

   localparam tab_type TANH_TAB = build_tab(CURVE_TANH);
   localparam tab_type ATAN_TAB = build_tab(CURVE_ATAN);
   localparam tab_type SINE_TAB = build_tab(CURVE_SINE);

   localparam logic [SW-1:0]         W_FULL   = SW'(1) << FW;
   localparam logic [TAB_BITS-1:0]   LAST_ROW = TAB_BITS'(TABLE_DEPTH - 1);
   localparam logic [TAB_BITS:0]     FILL_END = (TAB_BITS + 1)'(TABLE_DEPTH);
   localparam logic signed [Y_W-1:0] ONE_Y    = Y_W'(1) <<< FRAC_BITS;
   localparam logic signed [Y_W-1:0] S_MAX    = Y_W'((1 << (SW - 1)) - 1);
   localparam logic signed [Y_W-1:0] S_MIN    = -(Y_W'(1) <<< (SW - 1));
   localparam logic signed [PROD_W:0] RND     = (PROD_W + 1)'(1) <<< (SW - 2);

   // ---------------- mode register ----------------
   logic [MODE_W-1:0] mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_BYPASS;
      end else if (csr_valid) begin
         mode_ff <= csr_wdata;
      end
   end

   // ---------------- table fill sweep ----------------
   // Row k of the RAM holds {t[k+1], t[k]} of every curve, so one read feeds
   // both interpolation points. Step n reads entry n and writes row n-1.
   logic [TAB_BITS:0]   fill_cnt_ff;
   logic                fill_done_ff;
   logic [TAB_W-1:0]    tanh_prev_ff, atan_prev_ff, sine_prev_ff;
   logic [TAB_W-1:0]    tanh_cur, atan_cur, sine_cur;
   logic [TAB_BITS-1:0] fill_row;
   logic                ram_we;
   logic [ROW_W-1:0]    ram_wdata;

   assign tanh_cur  = TANH_TAB[fill_cnt_ff];
   assign atan_cur  = ATAN_TAB[fill_cnt_ff];
   assign sine_cur  = SINE_TAB[fill_cnt_ff];
   assign fill_row  = fill_cnt_ff[TAB_BITS-1:0] - 1'b1;
   assign ram_we    = !fill_done_ff && (fill_cnt_ff != '0);
   assign ram_wdata = {sine_cur, sine_prev_ff, atan_cur, atan_prev_ff,
                       tanh_cur, tanh_prev_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff  <= '0;
         fill_done_ff <= 1'b0;
      end else if (!fill_done_ff) begin
         fill_cnt_ff <= fill_cnt_ff + 1'b1;
         if (fill_cnt_ff == FILL_END) begin
            fill_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      tanh_prev_ff <= tanh_cur;
      atan_prev_ff <= atan_cur;
      sine_prev_ff <= sine_cur;
   end

   // ---------------- pipeline flow control ----------------
   // Each stage advances when the one after it moves or is empty, so bubbles
   // collapse and a request is still taken while a result waits.
   logic a_valid_ff, b_valid_ff, c_valid_ff, rsp_valid_ff;
   logic en_out, en_c, en_b, en_a;

   assign en_out     = !rsp_valid_ff || rsp_tready;
   assign en_c       = en_out || !c_valid_ff;
   assign en_b       = en_c || !b_valid_ff;
   assign en_a       = en_b || !a_valid_ff;
   assign req_tready = fill_done_ff && en_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en_a)   a_valid_ff   <= req_tvalid && req_tready;
         if (en_b)   b_valid_ff   <= a_valid_ff;
         if (en_c)   c_valid_ff   <= b_valid_ff;
         if (en_out) rsp_valid_ff <= c_valid_ff;
      end
   end

   // ---------------- stage A: magnitude and table position ----------------
   logic [SW-1:0]       a_sample_ff;
   logic                a_neg;
   logic [SW-1:0]       a_abs;
   logic [POS_W-1:0]    a_pos;
   logic [TAB_BITS:0]   a_idx;
   logic                a_last;
   logic [TAB_BITS-1:0] a_raddr;

   always_ff @(posedge clock) begin
      if (en_a) a_sample_ff <= req_tdata;
   end

   assign a_neg   = a_sample_ff[SW-1];
   assign a_abs   = a_neg ? (~a_sample_ff + 1'b1) : a_sample_ff;  // most negative -> 2^(SW-1)
   assign a_pos   = {a_abs, TAB_BITS'(0)};                       // |x| * TABLE_DEPTH
   assign a_idx   = a_pos[POS_W-1:FW];
   // only |x| = 8 lands past the end; use the top entry of the last row
   assign a_last  = a_idx[TAB_BITS];
   assign a_raddr = a_last ? LAST_ROW : a_idx[TAB_BITS-1:0];

   logic [ROW_W-1:0] ram_rdata;

   mws_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH)
   ) u_tab_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_row),
      .wr_data (ram_wdata),
      .rd_en   (en_b),
      .rd_addr (a_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------- stage B: pick curve, weight both entries ----------------
   logic [SW-1:0]            b_sample_ff;
   logic                     b_neg_ff, b_last_ff;
   logic [FW-1:0]            b_frac_ff;
   logic signed [TAB_W-1:0]  b_lo, b_hi, b_t0;
   logic [SW-1:0]            b_w0, b_w1;
   logic signed [PROD_W-1:0] b_p0, b_p1;

   always_ff @(posedge clock) begin
      if (en_b) begin
         b_sample_ff <= a_sample_ff;
         b_neg_ff    <= a_neg;
         b_last_ff   <= a_last;
         b_frac_ff   <= a_pos[FW-1:0];
      end
   end

   always_comb begin
      case (mode_ff)
         MODE_ATAN: begin
            b_lo = ram_rdata[2*TAB_W +: TAB_W];
            b_hi = ram_rdata[3*TAB_W +: TAB_W];
         end
         MODE_SINE: begin
            b_lo = ram_rdata[4*TAB_W +: TAB_W];
            b_hi = ram_rdata[5*TAB_W +: TAB_W];
         end
         default: begin
            b_lo = ram_rdata[0 +: TAB_W];
            b_hi = ram_rdata[TAB_W +: TAB_W];
         end
      endcase
   end

   assign b_t0 = b_last_ff ? b_hi : b_lo;
   assign b_w1 = {1'b0, b_frac_ff};
   assign b_w0 = W_FULL - b_w1;
   assign b_p0 = b_t0 * $signed({1'b0, b_w0});
   assign b_p1 = b_hi * $signed({1'b0, b_w1});

   // ---------------- stage C: round, restore sign, select, saturate ----------------
   logic [SW-1:0]            c_sample_ff;
   logic                     c_neg_ff;
   logic signed [PROD_W-1:0] c_p0_ff, c_p1_ff;
   logic signed [PROD_W:0]   c_num;
   logic signed [PROD_W:0]   c_shift;
   logic signed [Y_W-1:0]    c_mag, c_interp, c_x, c_y, c_sat;
   logic [SW-1:0]            rsp_data_ff;

   always_ff @(posedge clock) begin
      if (en_c) begin
         c_sample_ff <= b_sample_ff;
         c_neg_ff    <= b_neg_ff;
         c_p0_ff     <= b_p0;
         c_p1_ff     <= b_p1;
      end
   end

   assign c_num    = (PROD_W + 1)'(c_p0_ff) + (PROD_W + 1)'(c_p1_ff) + RND;
   assign c_shift  = c_num >>> FW;
   assign c_mag    = c_shift[Y_W-1:0];
   assign c_interp = c_neg_ff ? -c_mag : c_mag;
   assign c_x      = Y_W'($signed(c_sample_ff));

   always_comb begin
      case (mode_ff)
         MODE_TANH, MODE_ATAN, MODE_SINE: c_y = c_interp;
         MODE_CLIP: begin
            if (c_x > ONE_Y)       c_y = ONE_Y;
            else if (c_x < -ONE_Y) c_y = -ONE_Y;
            else                   c_y = c_x;
         end
         MODE_RECT: c_y = c_x[Y_W-1] ? -c_x : c_x;
         default:   c_y = c_x;   // bypass, and the unused codes
      endcase
   end

   // clamp to the sample range (rectify of the most negative input)
   always_comb begin
      if (c_y > S_MAX)      c_sat = S_MAX;
      else if (c_y < S_MIN) c_sat = S_MIN;
      else                  c_sat = c_y;
   end

   always_ff @(posedge clock) begin
      if (en_out) rsp_data_ff <= c_sat[SW-1:0];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
